// ----- rtl/double_ended_queue_macros.svh -----
// ---------------------------------------------------------------------------
// double_ended_queue_macros.svh
// Assertion shorthands shared by the deque RTL files.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define DQ_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define DQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dq_pkg.sv -----
// ---------------------------------------------------------------------------
// dq_pkg
// Action and status codes, beat widths and the command/status bundles that
// join the deque controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    // Input beat: action and value packed, padded to whole bytes
    localparam int IN_TDATA_W = ((ACTION_W + DATA_W + 7) / 8) * 8;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Action codes
    localparam action_t ACT_PUSH_FRONT = 3'd0;
    localparam action_t ACT_PUSH_BACK  = 3'd1;
    localparam action_t ACT_POP_FRONT  = 3'd2;
    localparam action_t ACT_POP_BACK   = 3'd3;
    localparam action_t ACT_DISPLAY    = 3'd4;

    // Result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    rd_back;      // read the back slot instead of front + index
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
        status_t out_status;
        logic    out_from_mem; // result data from the read port, else zero
        logic    out_last;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_last;        // display index sits on the back element
    } stat_t;

endpackage

// ----- rtl/double_ended_queue.sv -----
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words on a ring store, with
// push/pop at both ends and a front-to-back display stream.
// ---------------------------------------------------------------------------
//  Port group   Dir   Beat contents
//  s_*          in    tdata: action[2:0], value[34:3]
//  m_*          out   tdata: status[1:0], data_out[33:2], occupancy above;
//                     tlast marks the final beat of an action
//
//  Push, unused action, and any full/empty report: accept, then the result beat.
//  Pop: accept, registered read of the ring store, then the result beat.
//  Display: accept, then per element one store read and one result beat.
//  One action at a time; input is held off until its last beat is taken.
//  A stalled result holds its beat; reset empties the queue at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[2:0], value[34:3], zero fill above
    input  logic [dq_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[1:0], data_out[33:2], occupancy from bit 34, zero fill above
    output logic [((34 + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                m_tlast
);
    import dq_pkg::*;

    localparam int CW      = $clog2(DEPTH + 1);
    localparam int OUT_W   = ((STATUS_W + DATA_W + CW + 7) / 8) * 8;

    cmd_t               cmd;
    stat_t              stat;
    action_t            action;
    logic signed [31:0] value;
    status_t            status;
    logic signed [31:0] data_out;
    logic [CW-1:0]      occupancy;
    logic               last;

    // Unpack the input beat
    assign action = s_tdata[ACTION_W-1:0];
    assign value  = s_tdata[ACTION_W+DATA_W-1:ACTION_W];

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (action),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .status    (status),
        .data_out  (data_out),
        .occupancy (occupancy),
        .last      (last)
    );

    // Pack the output beat
    assign m_tdata = OUT_W'({occupancy, data_out, status});
    assign m_tlast = last;

endmodule

// ----- rtl/dq_ctrl.sv -----
// ---------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the deque: decodes one action, steps pops through the read
// port and walks a display one element per result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module dq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  dq_pkg::action_t action,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  dq_pkg::stat_t   stat,
    output dq_pkg::cmd_t    cmd
);
    import dq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       disp_reg;
    logic       disp_next;

    // Decode actions and sequence the result beats
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        disp_next  = disp_reg;
        s_tready   = (state_reg == S_IDLE);
        m_tvalid   = (state_reg == S_SEND);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (action) inside
                        ACT_PUSH_FRONT, ACT_PUSH_BACK:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_last = 1'b1;
                            if (stat.full)
                            begin
                                cmd.out_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.push_front = (action == ACT_PUSH_FRONT);
                                cmd.push_back  = (action == ACT_PUSH_BACK);
                                cmd.out_status = ST_OK;
                            end
                            state_next = S_SEND;
                        end
                        ACT_POP_FRONT, ACT_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                                state_next     = S_SEND;
                            end
                            else
                            begin
                                cmd.pop_front = (action == ACT_POP_FRONT);
                                cmd.pop_back  = (action == ACT_POP_BACK);
                                cmd.rd_back   = (action == ACT_POP_BACK);
                                disp_next     = 1'b0;
                                state_next    = S_READ;
                            end
                        end
                        ACT_DISPLAY:
                        begin
                            if (stat.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                                state_next     = S_SEND;
                            end
                            else
                            begin
                                disp_next  = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            // Unused codes: report ok and change nothing
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_OK;
                            state_next     = S_SEND;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // Read data is registered; capture it into the result beat
                cmd.out_load     = 1'b1;
                cmd.out_status   = ST_OK;
                cmd.out_from_mem = 1'b1;
                cmd.out_last     = !disp_reg || stat.idx_last;
                state_next       = S_SEND;
            end
            S_SEND:
            begin
                if (m_tready)
                begin
                    if (disp_reg && !stat.idx_last)
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        disp_next   = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and display mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            disp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            disp_reg  <= disp_next;
        end
    end

    `DQ_ASSERT_IMPL(a_no_overlap, clk, rst_n, 1'b1, !(s_tready && m_tvalid), "input and output both open")
    `DQ_ASSERT_IMPL(a_idle_no_disp, clk, rst_n, state_reg == S_IDLE, !disp_reg, "display mode left set in idle")
    `DQ_ASSERT_NEXT(a_read_to_send, clk, rst_n, state_reg == S_READ, m_tvalid, "read beat not presented")

endmodule

// ----- rtl/dq_dpath.sv -----
// ---------------------------------------------------------------------------
// dq_dpath
// Ring store, front pointer, element count, display index and the result
// register of the deque.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module dq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dq_pkg::cmd_t                     cmd,
    output dq_pkg::stat_t                    stat,
    input  logic signed [31:0]               value,
    output dq_pkg::status_t                  status,
    output logic signed [31:0]               data_out,
    output logic [$clog2(DEPTH+1)-1:0]       occupancy,
    output logic                             last
);
    import dq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW:0]   DEPTH_S = (IW + 1)'(DEPTH);
    localparam logic [IW-1:0] TOP_POS = IW'(DEPTH - 1);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    logic [IW-1:0] front_reg;
    logic [IW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;

    status_t            status_reg;
    logic signed [31:0] data_out_reg;
    logic [CW-1:0]      occupancy_reg;
    logic               last_reg;

    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] back_pos;
    logic [IW-1:0] tail_pos;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic          single;

    // Ring addition; both terms stay below DEPTH, so one subtract wraps it
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IW-1:0];
    endfunction

    // Ring positions around the front
    always_comb
    begin
        front_dec = (front_reg == '0) ? TOP_POS : front_reg - IW'(1);
        front_inc = ring_add(front_reg, IW'(1));
        back_pos  = ring_add(front_reg, IW'(count_reg - CW'(1)));
        tail_pos  = ring_add(front_reg, IW'(count_reg));
        single    = (count_reg == CW'(1));
    end

    // Advance or clear the display index
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    assign rd_addr = cmd.rd_back ? back_pos : ring_add(front_reg, idx_next);

    // Update pointer, count and write port
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_pos;
        if (cmd.push_front)
        begin
            front_next = front_dec;
            wr_en      = 1'b1;
            wr_addr    = front_dec;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.push_back)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_front)
        begin
            front_next = single ? '0 : front_inc;
            count_next = count_reg - CW'(1);
        end
        else if (cmd.pop_back)
        begin
            front_next = single ? '0 : front_reg;
            count_next = count_reg - CW'(1);
        end
    end

    assign stat.full     = (count_reg == DEPTH_C);
    assign stat.empty    = (count_reg == '0);
    assign stat.idx_last = (CW'(idx_reg) + CW'(1) == count_reg);

    // Hold ring pointer, count and display index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg    <= cmd.out_status;
            data_out_reg  <= cmd.out_from_mem ? rd_data_reg : '0;
            occupancy_reg <= count_next;
            last_reg      <= cmd.out_last;
        end
    end

    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign occupancy = occupancy_reg;
    assign last      = last_reg;

    `DQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C, "count above depth")
    `DQ_ASSERT_IMPL(a_empty_front, clk, rst_n, count_reg == '0, front_reg == '0, "empty ring with front off zero")
    `DQ_ASSERT_NEXT(a_push_count, clk, rst_n, cmd.push_front || cmd.push_back, count_reg == $past(count_reg) + CW'(1), "push did not grow count")
    `DQ_ASSERT_IMPL(a_idx_bound, clk, rst_n, idx_reg != '0, CW'(idx_reg) < count_reg, "display index past back")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of double_ended_queue. Every action beat sent in is run
// through a local ring-buffer predictor. Each result beat that comes back is
// compared field by field with the oldest predicted beat. Both the sender
// and the receiver stall in random bursts, except during the final stretch.
// ---------------------------------------------------------------------------

module testbench;

    import dq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int OUT_W      = ((34 + OCC_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 40;
    localparam int MAX_SHOWN  = 10;

    // Action codes the block ignores
    localparam action_t ACT_SPARE_5 = 3'd5;
    localparam action_t ACT_SPARE_6 = 3'd6;
    localparam action_t ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        status_t          status;
        logic [31:0]      data;
        logic [OCC_W-1:0] occupancy;
        logic             last;
    } deque_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tlast;

    // Predictor state: ring store, front slot and element count
    logic [31:0]   ring_store [DEPTH];
    int unsigned   ring_head;
    int unsigned   ring_count;

    deque_result_t expected_results [$];
    int unsigned   failures;
    int unsigned   idle_cycles;
    bit            quiet;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ring slot for a position that may run past the top
    function automatic logic [IDX_W-1:0] slot(int unsigned pos);
        return IDX_W'(pos % DEPTH);
    endfunction

    // Work out the result beats that one action causes
    function automatic void predict_action(action_t act, logic [31:0] val);
        deque_result_t r;
        int unsigned   i;
        r = '0;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (ring_count == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (act == ACT_PUSH_FRONT)
                    begin
                        ring_head = (ring_head + DEPTH - 1) % DEPTH;
                        ring_store[slot(ring_head)] = val;
                    end
                    else
                        ring_store[slot(ring_head + ring_count)] = val;
                    ring_count++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (ring_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (act == ACT_POP_FRONT)
                    begin
                        r.data = ring_store[slot(ring_head)];
                        ring_head = (ring_head + 1) % DEPTH;
                    end
                    else
                        r.data = ring_store[slot(ring_head + ring_count - 1)];
                    ring_count--;
                    if (ring_count == 0)
                        ring_head = 0;
                end
            end
            ACT_DISPLAY:
            begin
                if (ring_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // One beat per element, front first
                    for (i = 0; i < ring_count; i++)
                    begin
                        r.data      = ring_store[slot(ring_head + i)];
                        r.occupancy = OCC_W'(ring_count);
                        r.last      = (i + 1 == ring_count);
                        expected_results.push_back(r);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = OCC_W'(ring_count);
        r.last      = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Send one action beat, with an optional idle burst ahead of it
    task automatic send_action(action_t act, logic [31:0] val);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        predict_action(act, val);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - 35){1'b0}}, val, act};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Pick a random push end
    function automatic action_t push_end();
        return ($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    endfunction

    function automatic action_t pop_end();
        return ($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
    endfunction

    // Random data word, leaning on the extremes now and then
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random action, biased toward growing or shrinking the queue
    task automatic send_random_action(bit filling);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            send_action(filling ? push_end() : pop_end(), random_word());
        else if (r < 82)
            send_action(filling ? pop_end() : push_end(), random_word());
        else if (r < 93)
            send_action(ACT_DISPLAY, random_word());
        else
            send_action(action_t'($urandom_range(0, 7)), random_word());
    endtask

    // Pops and display on an empty queue report empty
    task automatic test_empty_reports();
        send_action(ACT_POP_FRONT, 32'hFFFF_FFFF);
        send_action(ACT_POP_BACK, 32'h0000_0000);
        send_action(ACT_DISPLAY, 32'hA5A5_A5A5);
    endtask

    // Unused codes are ignored, both empty and with data held
    task automatic test_spare_actions();
        send_action(ACT_SPARE_5, 32'hFFFF_FFFF);
        send_action(ACT_PUSH_BACK, 32'h1234_5678);
        send_action(ACT_SPARE_6, 32'h0000_0000);
        send_action(ACT_SPARE_7, 32'h5A5A_5A5A);
        send_action(ACT_POP_FRONT, 32'h0000_0000);
    endtask

    // Extreme words through both ends, front push wrapping the ring
    task automatic test_extreme_values();
        send_action(ACT_PUSH_FRONT, 32'h8000_0000);
        send_action(ACT_PUSH_BACK, 32'h7FFF_FFFF);
        send_action(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_action(ACT_PUSH_BACK, 32'h0000_0000);
        send_action(ACT_DISPLAY, 32'h0000_0000);
        send_action(ACT_POP_FRONT, 32'h0000_0000);
        send_action(ACT_POP_BACK, 32'h0000_0000);
        send_action(ACT_POP_BACK, 32'h0000_0000);
        send_action(ACT_POP_FRONT, 32'h0000_0000);
        send_action(ACT_POP_BACK, 32'h0000_0000);
    endtask

    // Fill to capacity, overflow at both ends, show all, then drain
    task automatic test_fill_and_overflow();
        int unsigned i;
        for (i = 0; i < DEPTH; i++)
            send_action(push_end(), random_word());
        send_action(ACT_PUSH_FRONT, random_word());
        send_action(ACT_PUSH_BACK, random_word());
        send_action(ACT_DISPLAY, random_word());
        for (i = 0; i < DEPTH; i++)
            send_action(pop_end(), random_word());
        send_action(ACT_DISPLAY, random_word());
    endtask

    // Swing between full and empty with random traffic
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned i;
        bit          filling;
        filling = 1'b1;
        for (i = 0; i < n_items; i++)
        begin
            if (filling && ring_count == DEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (!filling && ring_count == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            send_random_action(filling);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        ring_head  = 0;
        ring_count = 0;
        failures   = 0;
        quiet      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reports();
        test_spare_actions();
        test_extreme_values();
        test_fill_and_overflow();
        test_random_traffic(360);
        quiet = 1'b1;
        test_random_traffic(60);
        s_tvalid <= 1'b0;

        // Drain, then give stray beats a chance to show up
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_results.size() != 0)
            failures += expected_results.size();
        if (failures == 0)
            $display("double_ended_queue: match");
        else
            $display("double_ended_queue: mismatch");
        $finish;
    end

    // Result side backpressure: ready runs mixed with stall bursts
    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Log a mismatch; only the first few get printed
    task automatic note_mismatch(string what, deque_result_t want, deque_result_t got);
        failures++;
        if (failures <= MAX_SHOWN)
            $display({"%0t %s: expected st=%0d data=%h occ=%0d last=%0d,",
                      " got st=%0d data=%h occ=%0d last=%0d"},
                     $realtime, what, want.status, want.data, want.occupancy, want.last,
                     got.status, got.data, got.occupancy, got.last);
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        deque_result_t got;
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status    = m_tdata[1:0];
            got.data      = m_tdata[33:2];
            got.occupancy = m_tdata[34 +: OCC_W];
            got.last      = m_tlast;
            if (expected_results.size() == 0)
                note_mismatch("unexpected beat", '0, got);
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    note_mismatch("wrong beat", want, got);
            end
        end
    end

    // Stop a hung run: too many cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("double_ended_queue: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
